// ----- design/wer_pkg.sv -----
// Shared constants for the windowed event rate meter.
// No dependencies; imported by windowed_event_rate_meter.
package wer_pkg;

   // Number of intervals averaged by the meter.
   localparam int WINDOW = 16;

   // Fixed field widths of the block's ports.
   localparam int TS_W       = 32;
   localparam int TPS_W      = 20;
   localparam int RATE_W     = 32;
   localparam int OUT_FILL_W = 5;
   localparam int FRAC_W     = 8;

   // Widths that follow from the window depth.
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = TS_W + SLOT_W;

   // Dividend and quotient widths of the rate division.
   localparam int PROD_W = TPS_W + FILL_W;
   localparam int NUM_W  = PROD_W + FRAC_W;
   localparam int DIV_W  = (NUM_W > RATE_W) ? NUM_W : RATE_W;
   localparam int CNT_W  = $clog2(DIV_W + 1);

   localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000);
   localparam logic [DIV_W-1:0]  RATE_MAX  = DIV_W'({RATE_W{1'b1}});

endpackage

// ----- design/windowed_event_rate_meter.sv -----
// Windowed event rate meter: interval ring memory, running sum and serial divider.
// Depends on wer_pkg for widths and the window depth.
//
// Each input word carries one event timestamp; each produces exactly one result word
// holding the average event rate over the last WINDOW intervals, as events per second
// with 8 fractional bits: floor(ticks_per_second * fill * 256 / sum), saturated to
// all ones. The first event after reset only starts the meter (zero interval). When
// the interval sum is zero the result carries no_rate = 1 and a zero rate. Timestamp
// differences wrap modulo 2^32. An event is accepted and the oldest interval read from
// the ring memory, then the new interval is written and the sum updated, then the
// division is set up (and skipped when the sum is zero), then the one-bit-per-cycle
// restoring divider forms the rate, and last the result is handed to the output
// register once that is free or being emptied. A new word is accepted the cycle after
// its predecessor's result moves into the output register, even while that result
// waits to be taken. The user is to write ticks_per_second over the csr port only
// while the meter is idle; the block itself does not enforce this. A write is taken
// at once (csr_ready is always high); ticks_per_second resets to 1000.
module windowed_event_rate_meter
   import wer_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TPS_W-1:0]      csr_ticks_per_second,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TS_W-1:0]       req_timestamp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RATE_W-1:0]     rsp_rate_fixed,
   output logic                  rsp_no_rate,
   output logic [OUT_FILL_W-1:0] rsp_window_fill
);

   // Sequencer codes. Only one event is in flight, so the ring read in S_IDLE and the
   // write in S_READ can never touch the same entry out of order.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // Interval ring: a synchronous memory. Each entry has a valid bit so that an
   // entry never written since reset reads as zero.
   logic [TS_W-1:0]     ring_mem [WINDOW];
   logic [TS_W-1:0]     rd_data_ff;
   logic [WINDOW-1:0]   valid_ff, valid_in;

   logic [2:0]          state_ff, state_in;
   logic [TPS_W-1:0]    tps_ff, tps_in;
   logic                started_ff, started_in;
   logic [TS_W-1:0]     last_ts_ff, last_ts_in;
   logic [TS_W-1:0]     gap_ff, gap_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                none_ff, none_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic                rsp_none_ff, rsp_none_in;
   logic [OUT_FILL_W-1:0] rsp_fill_ff, rsp_fill_in;

   logic                req_fire;
   logic                ring_we;
   logic [TS_W-1:0]     old_gap;
   logic [SUM_W:0]      rem_shift;
   logic [SUM_W+1:0]    trial;

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == S_IDLE);
   assign req_fire        = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rate_fixed  = rsp_rate_ff;
   assign rsp_no_rate     = rsp_none_ff;
   assign rsp_window_fill = rsp_fill_ff;

   // Oldest interval leaving the window; zero if its slot was never written.
   assign old_gap   = valid_ff[slot_ff] ? rd_data_ff : '0;
   // One restoring division step: shift in the next dividend bit and try a subtract.
   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, sum_ff};
   assign ring_we   = (state_ff == S_READ);

   always_comb begin
      state_in     = state_ff;
      tps_in       = csr_valid ? csr_ticks_per_second : tps_ff;
      started_in   = started_ff;
      last_ts_in   = last_ts_ff;
      gap_in       = gap_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      none_in      = none_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rate_in  = rsp_rate_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_fill_in  = rsp_fill_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // The first event after reset sees a zero interval.
               gap_in     = started_ff ? (req_timestamp - last_ts_ff) : '0;
               last_ts_in = req_timestamp;
               started_in = 1'b1;
               if (fill_ff != FILL_W'(WINDOW)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            sum_in          = sum_ff - SUM_W'(old_gap) + SUM_W'(gap_ff);
            valid_in[slot_ff] = 1'b1;
            slot_in         = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            prod_in         = PROD_W'(tps_ff) * PROD_W'(fill_ff);
            state_in        = S_PREP;
         end
         S_PREP: begin
            if (sum_ff == '0) begin
               none_in  = 1'b1;
               quo_in   = '0;
               state_in = S_DONE;
            end else begin
               none_in  = 1'b0;
               quo_in   = DIV_W'({prod_ff, FRAC_W'(0)});
               rem_in   = '0;
               cnt_in   = CNT_W'(DIV_W);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[SUM_W+1]) begin
               rem_in = trial[SUM_W-1:0];
            end else begin
               rem_in = rem_shift[SUM_W-1:0];
            end
            quo_in = {quo_ff[DIV_W-2:0], !trial[SUM_W+1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hand the result to the output register once it is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = (quo_ff > RATE_MAX) ? {RATE_W{1'b1}} : RATE_W'(quo_ff);
               rsp_none_in  = none_ff;
               rsp_fill_in  = OUT_FILL_W'(fill_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Ring memory: one read port, one write port, registered read data.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= ring_mem[slot_ff];
      end
      if (ring_we) begin
         ring_mem[slot_ff] <= gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tps_ff       <= TPS_RESET;
         started_ff   <= 1'b0;
         last_ts_ff   <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         started_ff   <= started_in;
         last_ts_ff   <= last_ts_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff      <= gap_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      none_ff     <= none_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_none_ff <= rsp_none_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   // The fill count saturates at the window depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("fill count exceeds window depth");

   // An accepted event always goes straight to the ring update.
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_READ)
      else $error("accepted event did not reach ring update");

   // The divider's partial remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> rem_ff < sum_ff)
      else $error("divider remainder not below divisor");

   // A result flagged as having no rate carries a zero rate.
   a_no_rate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_ff) |-> rsp_rate_ff == '0)
      else $error("no-rate result with nonzero rate");

endmodule

// ----- verif/tb_windowed_event_rate_meter.sv -----
// Self-checking testbench for windowed_event_rate_meter: directed and random event timestamps,
// several tick scales, random pauses on both handshakes. Depends on wer_pkg and the RTL only.
module tb_windowed_event_rate_meter;
   import wer_pkg::*;

   // One result word as the block presents it on the rsp_ port.
   typedef struct packed {
      logic [RATE_W-1:0]     rate;
      logic                  no_rate;
      logic [OUT_FILL_W-1:0] fill;
   } rate_word_type;

   typedef logic [TS_W-1:0] stamp_q_type [$];

   // Cycles with no handshake on any port before the run is declared hung. The slowest
   // legal stretch is a long sender pause, the full serial division and a long receiver
   // stall back to back, which stays well under this limit.
   localparam int unsigned HANG_LIMIT = 2000;

   // Cycles allowed after the last result for a stray word to show up.
   localparam int unsigned SETTLE_CYCLES = 60;

   // Mismatch reports are capped so that a badly broken build keeps the log readable.
   localparam int unsigned REPORT_CAP = 40;

   // Tracks the meter state from accepted words and keeps the rate words still owed.
   class rate_scoreboard;
      logic [TPS_W-1:0] scale;
      logic [TS_W-1:0]  intervals [WINDOW];
      logic [SUM_W-1:0] span_sum;
      int unsigned      next_slot;
      int unsigned      filled;
      logic [TS_W-1:0]  prev_stamp;
      bit               running;
      rate_word_type    owed_rates [$];
      int unsigned      mismatches;
      int unsigned      events_seen;
      int unsigned      words_checked;
      int unsigned      no_rate_words;
      int unsigned      full_window_words;
      int unsigned      scale_writes;

      function new();
         scale = TPS_RESET;
         foreach (intervals[i]) intervals[i] = '0;
         span_sum = '0;
         next_slot = 0;
         filled = 0;
         prev_stamp = '0;
         running = 1'b0;
         mismatches = 0;
         events_seen = 0;
         words_checked = 0;
         no_rate_words = 0;
         full_window_words = 0;
         scale_writes = 0;
      endfunction

      function void set_scale(input logic [TPS_W-1:0] value);
         scale = value;
         scale_writes++;
      endfunction

      function void note_event(input logic [TS_W-1:0] stamp);
         logic [TS_W-1:0] gap;
         logic [63:0]     dividend;
         logic [63:0]     quotient;
         rate_word_type   word;
         if (!running) begin
            prev_stamp = stamp;
            running = 1'b1;
         end
         gap = stamp - prev_stamp;
         prev_stamp = stamp;
         span_sum = span_sum - SUM_W'(intervals[next_slot]) + SUM_W'(gap);
         intervals[next_slot] = gap;
         next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
         if (filled < WINDOW) filled++;
         word.fill = OUT_FILL_W'(filled);
         if (span_sum == '0) begin
            word.no_rate = 1'b1;
            word.rate = '0;
         end else begin
            dividend = (64'(scale) * 64'(filled)) << FRAC_W;
            quotient = dividend / 64'(span_sum);
            word.no_rate = 1'b0;
            word.rate = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[RATE_W-1:0];
         end
         owed_rates.push_back(word);
         events_seen++;
      endfunction

      function void flag(input string what, input logic [63:0] want, input logic [63:0] got);
         if (mismatches < REPORT_CAP)
            $error("%s mismatch: expected %0d, actual %0d", what, want, got);
         mismatches++;
      endfunction

      function void check_result(input rate_word_type got);
         rate_word_type want;
         if (owed_rates.size() == 0) begin
            if (mismatches < REPORT_CAP)
               $error("rate word arrived with no event waiting for it");
            mismatches++;
            return;
         end
         want = owed_rates.pop_front();
         words_checked++;
         if (want.no_rate) no_rate_words++;
         if (want.fill == OUT_FILL_W'(WINDOW)) full_window_words++;
         if (got.rate !== want.rate) flag("rate_fixed", want.rate, got.rate);
         if (got.no_rate !== want.no_rate) flag("no_rate", want.no_rate, got.no_rate);
         if (got.fill !== want.fill) flag("window_fill", want.fill, got.fill);
      endfunction

      function int unsigned pending();
         return owed_rates.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TPS_W-1:0]      csr_ticks_per_second = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TS_W-1:0]       req_timestamp = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RATE_W-1:0]     rsp_rate_fixed;
   logic                  rsp_no_rate;
   logic [OUT_FILL_W-1:0] rsp_window_fill;

   rate_scoreboard rates = new();

   // While set, neither the sender nor the receiver pauses, so words go back to back.
   bit no_pauses = 1'b0;

   // Running timestamp that the random bursts advance from one burst to the next.
   logic [TS_W-1:0] stamp_cursor = '0;

   int unsigned quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   windowed_event_rate_meter u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_ticks_per_second (csr_ticks_per_second),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_timestamp        (req_timestamp),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rate_fixed       (rsp_rate_fixed),
      .rsp_no_rate          (rsp_no_rate),
      .rsp_window_fill      (rsp_window_fill)
   );

   // Pause length in cycles: mostly none, often a short one, now and then a long one so
   // that the pause can straddle every phase of the serial division.
   function automatic int unsigned pick_pause();
      int unsigned roll;
      if (no_pauses) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sends a list of timestamps, one word per handshake. Valid stays high across words
   // that follow with no pause, also from one list to the next, so it is never dropped
   // and raised at the same edge. The caller lowers valid once the whole stream is sent.
   task automatic send_events(input stamp_q_type stamps);
      int unsigned pause;
      foreach (stamps[i]) begin
         pause = pick_pause();
         if (pause != 0) begin
            req_valid <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_timestamp <= stamps[i];
         do @(posedge clock); while (!req_ready);
      end
   endtask

   // Waits until every owed rate word has been taken, then for a closing edge. An opening
   // edge lets the monitor record the word accepted at the edge this task is entered on.
   task automatic wait_drained();
      @(posedge clock);
      while (rates.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Writes ticks_per_second; only ever called once the meter has drained.
   task automatic write_scale(input logic [TPS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_ticks_per_second <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Builds and sends random bursts until at least the given number of events is sent.
   // Most bursts are steady trains of intervals with random spacing and jitter, which is
   // what drives the window through fill and wrap of the ring; some of them start just
   // below a counter wrap. The rest are frozen runs (one timestamp repeated until the sum
   // drains back to zero) and scattered timestamps that exercise every bit of the field.
   task automatic run_random_phase(input int unsigned count);
      stamp_q_type burst;
      int unsigned sent;
      int unsigned kind;
      int unsigned span;
      int unsigned roll;
      logic [TS_W-1:0] base_gap;
      logic [TS_W-1:0] jitter;
      sent = 0;
      while (sent < count) begin
         burst.delete();
         no_pauses = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 7 || kind == 9) begin
            if (kind == 9) stamp_cursor = 32'hFFFF_FFFF - $urandom_range(0, 500);
            roll = $urandom_range(0, 9);
            if (roll < 5) base_gap = $urandom_range(1, 20);
            else if (roll < 8) base_gap = $urandom_range(100, 200000);
            else base_gap = $urandom;
            jitter = ($urandom_range(0, 2) == 0) ? '0 : (base_gap >> 2);
            span = $urandom_range(8, 24);
            repeat (span) begin
               stamp_cursor = stamp_cursor + base_gap + $urandom_range(0, jitter);
               burst.push_back(stamp_cursor);
            end
         end else if (kind == 7) begin
            span = $urandom_range(WINDOW, WINDOW + 4);
            repeat (span) burst.push_back(stamp_cursor);
         end else begin
            span = $urandom_range(1, 4);
            repeat (span) begin
               stamp_cursor = $urandom;
               burst.push_back(stamp_cursor);
            end
         end
         send_events(burst);
         sent += burst.size();
      end
      req_valid <= 1'b0;
      no_pauses = 1'b0;
   endtask

   // Observes every handshake at the clock edge where it completes and feeds the model.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) rates.set_scale(csr_ticks_per_second);
         if (req_valid && req_ready) rates.note_event(req_timestamp);
         if (rsp_valid && rsp_ready)
            rates.check_result('{rate: rsp_rate_fixed, no_rate: rsp_no_rate,
                                 fill: rsp_window_fill});
      end
   end

   // Watchdog: counts edges with no handshake on any port.
   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_valid && req_ready) ||
          (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("Timed out after %0d cycles with no word moving", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: takes rate words with random stalls in between, and with stretches
   // without any stall while no_pauses is set.
   initial begin
      int unsigned stall;
      @(posedge clock);
      forever begin
         stall = pick_pause();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      stamp_q_type      directed;
      logic [TPS_W-1:0] scales [$];
      logic [TS_W-1:0]  stamp;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset scale of 1000 ticks per second. The first word only
      // starts the meter, and its repeat keeps the interval sum at zero, so both give
      // no_rate. Then a plain short interval, a near-full-range jump, two counter wraps
      // (one of them by a single tick), alternating bit patterns, and a steady train
      // long enough to fill the window and start overwriting the ring.
      directed = '{32'd100, 32'd100, 32'd110, 32'd112, 32'hFFFF_FFF0, 32'h0000_0005,
                   32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h8000_0001,
                   32'hAAAA_AAAA, 32'h5555_5555};
      stamp = 32'h5555_5555;
      repeat (WINDOW - 4) begin
         stamp = stamp + 3;
         directed.push_back(stamp);
      end
      send_events(directed);
      req_valid <= 1'b0;
      wait_drained();
      stamp_cursor = stamp;

      // One random phase at the reset scale, then one per written scale: the smallest
      // legal value, the largest legal value, all ones, zero (rate is zero whenever the
      // sum is not), a random one, and finally back to the reset value.
      run_random_phase(80);
      wait_drained();
      scales = '{TPS_W'(1), TPS_W'(1000000), '1, '0, TPS_W'($urandom_range(2, 999999)),
                 TPS_RESET};
      foreach (scales[i]) begin
         write_scale(scales[i]);
         run_random_phase(80);
         wait_drained();
      end

      // Let any stray word surface before the final verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rates.pending() != 0) begin
         $error("%0d rate words were never delivered", rates.pending());
         rates.mismatches++;
      end

      $display("Sent %0d events under %0d tick scales and checked %0d rate words,",
               rates.events_seen, rates.scale_writes + 1, rates.words_checked);
      $display("%0d of them with no rate and %0d averaged over a full window.",
               rates.no_rate_words, rates.full_window_words);
      if (rates.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
